// File: src/stack_calculator_macros.svh
// ----------------------------------------------------------------------------
// stack calculator assertion macros
// shared concurrent assertion forms for the stack calculator rtl
// ----------------------------------------------------------------------------
`ifndef STACK_CALCULATOR_MACROS_SVH
`define STACK_CALCULATOR_MACROS_SVH

// same-cycle implication
`define STKC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STKC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/stkc_pkg.sv
// ----------------------------------------------------------------------------
// stack calculator package
// request codes and the fixed request type width shared by the stack calculator rtl
// ----------------------------------------------------------------------------
`default_nettype none

package stkc_pkg;

   localparam int REQ_TYPE_WIDTH = 3;

   localparam logic [REQ_TYPE_WIDTH-1:0] OP_PUSH = 3'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_POP  = 3'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_SUB  = 3'd2;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_MUL  = 3'd3;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_SWAP = 3'd4;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_NEG  = 3'd5;

endpackage

`default_nettype wire

// File: src/stkc_req_if.sv
// ----------------------------------------------------------------------------
// stack calculator request channel
// valid/ready channel carrying one calculator request per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface stkc_req_if #(
   parameter int DATA_WIDTH = 32
);
   import stkc_pkg::*;

   logic                               valid;
   logic                               ready;
   logic        [REQ_TYPE_WIDTH-1:0]   req_type;
   logic signed [DATA_WIDTH-1:0]       push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);

endinterface

`default_nettype wire

// File: src/stkc_rsp_if.sv
// ----------------------------------------------------------------------------
// stack calculator response channel
// valid/ready channel carrying one calculator result per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface stkc_rsp_if #(
   parameter int DATA_WIDTH  = 32,
   parameter int DEPTH_WIDTH = 5
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_value;
   logic                         stack_underflow;
   logic                         stack_overflow;
   logic        [DEPTH_WIDTH-1:0] depth_after;

   modport source (output valid, output result_value, output stack_underflow,
                   output stack_overflow, output depth_after, input ready);
   modport sink   (input valid, input result_value, input stack_underflow,
                   input stack_overflow, input depth_after, output ready);

endinterface

`default_nettype wire

// File: src/stack_calculator.sv
// ----------------------------------------------------------------------------
// stack calculator
// bounded integer stack calculator: push, pop, subtract, multiply, swap and
// negate on a stack held in a two-read, one-write synchronous memory
// ----------------------------------------------------------------------------
// usage
//   req: valid/ready channel, one request (req_type, push_value) per
//   transaction. ready is high while the sequencer is idle.
//   rsp: valid/ready channel, one result per request, in request order.
//   sequence: a taken request passes the read state, which registers the
//   operands, and the execute state, which loads the output register; swap
//   adds a second write state, as it writes two stack entries through the
//   single memory write port. a new request is taken only when idle.
//   a new request is taken while the previous result still waits in the
//   output register; execution then holds until that result is taken, so a
//   stalled receiver stops the block after at most one request in flight.
//   reset: synchronous, clears the sequencer, the depth and the output valid.
//   the stack memory is not cleared; only entries below the depth are used.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_calculator_macros.svh"

module stack_calculator #(
   parameter int STACK_DEPTH = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   stkc_req_if.sink    req,
   stkc_rsp_if.source  rsp
);
   import stkc_pkg::*;

   localparam int ADDR_WIDTH  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DEPTH_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_FULL = DEPTH_WIDTH'(STACK_DEPTH);
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_ONE  = DEPTH_WIDTH'(1);
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_TWO  = DEPTH_WIDTH'(2);
   localparam logic [DATA_WIDTH-1:0]  ALL_ONES   = '1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_SWAP2
   } state_type;

   state_type                  state_ff;
   logic [REQ_TYPE_WIDTH-1:0]  op_ff;
   logic [DATA_WIDTH-1:0]      push_ff;
   logic [DEPTH_WIDTH-1:0]     depth_ff;
   logic [DEPTH_WIDTH-1:0]     depth_in;
   logic [DATA_WIDTH-1:0]      top_rd_ff;
   logic [DATA_WIDTH-1:0]      sec_rd_ff;
   logic [DATA_WIDTH-1:0]      swap_data_ff;
   logic [DATA_WIDTH-1:0]      swap_data_in;
   logic [ADDR_WIDTH-1:0]      swap_addr_ff;
   logic [ADDR_WIDTH-1:0]      swap_addr_in;

   logic                       rsp_valid_ff;
   logic [DATA_WIDTH-1:0]      result_ff;
   logic [DATA_WIDTH-1:0]      result_in;
   logic                       underflow_ff;
   logic                       underflow_in;
   logic                       overflow_ff;
   logic                       overflow_in;
   logic [DEPTH_WIDTH-1:0]     depth_out_ff;

   logic [DATA_WIDTH-1:0]      mem [STACK_DEPTH];
   logic                       wr_en;
   logic [ADDR_WIDTH-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0]      wr_data;
   logic [DEPTH_WIDTH-1:0]     depth_m1;
   logic [DEPTH_WIDTH-1:0]     depth_m2;

   logic                       req_take;
   logic                       exec_go;
   logic                       has_top;
   logic                       has_sec;
   logic [DATA_WIDTH-1:0]      opnd_a;
   logic [DATA_WIDTH-1:0]      opnd_b;
   logic [DEPTH_WIDTH-1:0]     base_one;
   logic [DEPTH_WIDTH-1:0]     base_two;
   logic [DEPTH_WIDTH-1:0]     base_two_p1;

   assign req.ready = (state_ff == S_IDLE);
   assign req_take  = req.valid && req.ready;
   assign exec_go   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.result_value    = result_ff;
   assign rsp.stack_underflow = underflow_ff;
   assign rsp.stack_overflow  = overflow_ff;
   assign rsp.depth_after     = depth_out_ff;

   // stack memory, two reads and one write
   assign depth_m1 = depth_ff - DEPTH_ONE;
   assign depth_m2 = depth_ff - DEPTH_TWO;

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         top_rd_ff <= mem[depth_m1[ADDR_WIDTH-1:0]];
         sec_rd_ff <= mem[depth_m2[ADDR_WIDTH-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // operand selection, missing operands read as all ones
   assign has_top     = (depth_ff != '0);
   assign has_sec     = (depth_ff > DEPTH_ONE);
   assign opnd_b      = has_top ? top_rd_ff : ALL_ONES;
   assign opnd_a      = has_sec ? sec_rd_ff : ALL_ONES;
   assign base_one    = has_top ? depth_m1 : '0;
   assign base_two    = has_sec ? depth_m2 : '0;
   assign base_two_p1 = base_two + DEPTH_ONE;

   always_comb begin
      result_in    = '0;
      underflow_in = 1'b0;
      overflow_in  = 1'b0;
      depth_in     = depth_ff;
      swap_data_in = opnd_a;
      swap_addr_in = base_two_p1[ADDR_WIDTH-1:0];
      wr_en        = 1'b0;
      wr_addr      = base_two[ADDR_WIDTH-1:0];
      wr_data      = opnd_b;
      case (op_ff)
         OP_PUSH: begin
            if (depth_ff != DEPTH_FULL) begin
               wr_en     = exec_go;
               wr_addr   = depth_ff[ADDR_WIDTH-1:0];
               wr_data   = push_ff;
               result_in = push_ff;
               depth_in  = depth_ff + DEPTH_ONE;
            end else begin
               overflow_in = 1'b1;
               result_in   = top_rd_ff;
            end
         end
         OP_POP: begin
            result_in    = opnd_b;
            underflow_in = !has_top;
            depth_in     = base_one;
         end
         OP_SUB: begin
            result_in    = opnd_a - opnd_b;
            underflow_in = !has_sec;
            wr_en        = exec_go;
            wr_data      = result_in;
            depth_in     = base_two_p1;
         end
         OP_MUL: begin
            result_in    = opnd_a * opnd_b;
            underflow_in = !has_sec;
            wr_en        = exec_go;
            wr_data      = result_in;
            depth_in     = base_two_p1;
         end
         OP_SWAP: begin
            result_in    = opnd_a;
            underflow_in = !has_sec;
            wr_en        = exec_go;
            wr_data      = opnd_b;
            depth_in     = base_two + DEPTH_TWO;
         end
         OP_NEG: begin
            result_in    = '0 - opnd_b;
            underflow_in = !has_top;
            wr_en        = exec_go;
            wr_addr      = base_one[ADDR_WIDTH-1:0];
            wr_data      = result_in;
            depth_in     = base_one + DEPTH_ONE;
         end
         default: begin
            result_in = has_top ? top_rd_ff : '0;
         end
      endcase
      // second write of a swap
      if (state_ff == S_SWAP2) begin
         wr_en   = 1'b1;
         wr_addr = swap_addr_ff;
         wr_data = swap_data_ff;
      end
   end

   // sequencer, stack depth and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && !exec_go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  state_ff <= S_READ;
                  op_ff    <= req.req_type;
                  push_ff  <= req.push_value;
               end
            end
            S_READ: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (exec_go) begin
                  depth_ff     <= depth_in;
                  rsp_valid_ff <= 1'b1;
                  result_ff    <= result_in;
                  underflow_ff <= underflow_in;
                  overflow_ff  <= overflow_in;
                  depth_out_ff <= depth_in;
                  swap_data_ff <= swap_data_in;
                  swap_addr_ff <= swap_addr_in;
                  state_ff     <= (op_ff == OP_SWAP) ? S_SWAP2 : S_IDLE;
               end
            end
            S_SWAP2: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `STKC_ASSERT_IMPLIES(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_FULL, "stack depth beyond capacity")
   `STKC_ASSERT_IMPLIES(a_write_state, clock, reset, wr_en, (state_ff == S_EXEC) || (state_ff == S_SWAP2), "memory write outside execute")
   `STKC_ASSERT_IMPLIES(a_overflow_full, clock, reset, rsp_valid_ff && overflow_ff, (depth_out_ff == DEPTH_FULL) && !underflow_ff, "overflow without a full stack")
   `STKC_ASSERT_NEXT(a_take_read, clock, reset, req_take, state_ff == S_READ, "accepted transaction did not start a read")
   `STKC_ASSERT_IMPLIES(a_hold_result, clock, reset, (state_ff == S_EXEC) && rsp_valid_ff && !rsp.ready, !wr_en, "execute ran over a waiting result")

endmodule

`default_nettype wire
